[hw/rtl/sensor_running_average_monitor_assert.svh]
// Assertion macros for the sensor running average monitor.
`ifndef SENSOR_RUNNING_AVERAGE_MONITOR_ASSERT_SVH
`define SENSOR_RUNNING_AVERAGE_MONITOR_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define SRAM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every rising clock edge outside reset.
`define SRAM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sram_pkg.sv]
package sram_pkg;

  localparam int Window     = 8;
  localparam int MaxSensors = 64;
  localparam int WinW       = $clog2(Window);
  localparam int EntW       = $clog2(MaxSensors);
  localparam int CntW       = $clog2(MaxSensors + 1);
  localparam int SumW       = 16 + WinW;
  localparam int WsAddrW    = EntW + WinW;

  localparam logic       CmdMap    = 1'b0;
  localparam logic       CmdSample = 1'b1;

  localparam logic [2:0] StDone    = 3'd0;
  localparam logic [2:0] StUnknown = 3'd1;
  localparam logic [2:0] StStored  = 3'd2;
  localparam logic [2:0] StFull    = 3'd3;
  localparam logic [2:0] StDup     = 3'd4;

  localparam logic [1:0] AlNone = 2'd0;
  localparam logic [1:0] AlCold = 2'd1;
  localparam logic [1:0] AlHot  = 2'd2;

  localparam logic CfgLow  = 1'b0;
  localparam logic CfgHigh = 1'b1;

  typedef struct packed {
    logic               command;
    logic [15:0]        probe_id;
    logic [15:0]        room_id;
    logic signed [15:0] sample_value;
    logic [31:0]        sample_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [15:0]        out_probe_id;
    logic [15:0]        out_room_id;
    logic signed [15:0] average;
    logic [31:0]        last_time;
    logic [1:0]         alarm;
  } out_item_t;

  // Search token passed along the cell row.
  typedef struct packed {
    logic            valid;
    logic [15:0]     id;
    logic            hit;
    logic [EntW-1:0] idx;
  } search_t;

endpackage

[hw/rtl/sram_stream_if.sv]
interface sram_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/sram_cell.sv]
module sram_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [sram_pkg::EntW-1:0] idx_i,
  input  logic                  load_i,
  input  logic [15:0]           load_id_i,
  input  logic                  used_i,
  input  sram_pkg::search_t     prev_i,
  output sram_pkg::search_t     next_o
);
  import sram_pkg::*;

  logic [15:0] id_q;
  search_t     next_q;
  search_t     next_d;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      id_q <= load_id_i;
    end
  end

  always_comb begin
    next_d = prev_i;
    if (prev_i.valid && !prev_i.hit && used_i && (id_q == prev_i.id)) begin
      next_d.hit = 1'b1;
      next_d.idx = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= '0;
    end else begin
      next_q <= next_d;
    end
  end

  assign next_o = next_q;
endmodule

[hw/rtl/sram_window.sv]
module sram_window (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clr_i,
  input  logic                         rd_i,
  input  logic                         wr_i,
  input  logic [sram_pkg::EntW-1:0]    ent_i,
  input  logic signed [15:0]           sample_i,
  output logic signed [sram_pkg::SumW-1:0] sum_o
);
  import sram_pkg::*;

  logic signed [15:0]   ws_mem [Window*MaxSensors];
  logic signed [SumW-1:0] sum_mem [MaxSensors];
  logic [WinW-1:0]      pos_mem [MaxSensors];
  logic signed [15:0]   old_q;
  logic signed [SumW-1:0] sum_q;
  logic [WinW-1:0]      pos_q;
  logic [WinW:0]        clr_cnt_q;
  logic [WsAddrW-1:0]   ws_addr;
  logic signed [SumW-1:0] new_sum;

  // Clearing sweeps one slot a cycle through the entry's window.
  assign ws_addr = clr_cnt_q != '0 ? {ent_i, clr_cnt_q[WinW-1:0]} : {ent_i, pos_q};
  assign new_sum = sum_q - SumW'(old_q) + SumW'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (clr_i) begin
      clr_cnt_q <= (WinW+1)'(Window);
    end else if (clr_cnt_q != '0) begin
      clr_cnt_q <= clr_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      sum_mem[ent_i] <= '0;
      pos_mem[ent_i] <= '0;
    end
    if (clr_cnt_q != '0 || wr_i) begin
      ws_mem[ws_addr] <= (clr_cnt_q != '0) ? '0 : sample_i;
    end
    if (rd_i) begin
      sum_q <= sum_mem[ent_i];
      pos_q <= pos_mem[ent_i];
    end
    old_q <= ws_mem[{ent_i, pos_q}];
    if (wr_i) begin
      sum_mem[ent_i]  <= new_sum;
      pos_mem[ent_i]  <= pos_q + 1'b1;
      sum_o           <= new_sum;
    end
  end
endmodule

[hw/rtl/sensor_running_average_monitor.sv]
// Sensor running average monitor.
// Each input first runs its id through the cell chain. An unknown sensor, a full table
// or a duplicate id then gives its result at once; a stored map entry first clears its
// sample window; a sample that hits reads, updates and averages its window first.
// Throughput: one transaction in flight; a new input is taken only after the result leaves.
// Reset (rst_ni low, asynchronous) empties the table and restores the limits.
module sensor_running_average_monitor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  sram_stream_if.sink                in_if,
  sram_stream_if.source              out_if,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [15:0]                cfg_data_i
);
  import sram_pkg::*;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SSearch = 3'd1;
  localparam logic [2:0] SRead   = 3'd2;
  localparam logic [2:0] SOld    = 3'd3;
  localparam logic [2:0] SUpd    = 3'd4;
  localparam logic [2:0] SClr    = 3'd5;
  localparam logic [2:0] SOut    = 3'd6;
  localparam logic [2:0] SAvg    = 3'd7;

  logic [2:0]  state_q, state_d;
  logic signed [15:0] low_q, high_q;
  logic [CntW-1:0] count_q;
  in_item_t    item_q;
  out_item_t   res_q;
  logic [EntW-1:0] ent_q;
  logic [WinW:0]   wait_q;
  logic [15:0] room_mem [MaxSensors];
  logic [15:0] room_rd_q;

  search_t chain [MaxSensors+1];
  search_t tail;
  logic signed [SumW-1:0] sum;
  logic signed [15:0] avg;
  logic full;

  assign full = count_q == CntW'(MaxSensors);
  assign chain[0] = '{valid: state_q == SIdle && in_if.valid, id: in_if.data.probe_id,
                      hit: 1'b0, idx: '0};
  assign tail = chain[MaxSensors];

  // Each cell holds one table id and checks the passing token against it.
  for (genvar g = 0; g < MaxSensors; g++) begin : g_cell
    sram_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (EntW'(g)),
      .load_i    (state_q == SSearch && tail.valid && item_q.command == CmdMap &&
                  !tail.hit && !full && count_q[EntW-1:0] == EntW'(g)),
      .load_id_i (item_q.probe_id),
      .used_i    (CntW'(g) < count_q),
      .prev_i    (chain[g]),
      .next_o    (chain[g+1])
    );
  end

  logic win_clr, win_rd, win_wr;
  assign win_clr = state_q == SSearch && tail.valid && item_q.command == CmdMap &&
                   !tail.hit && !full;
  assign win_rd  = state_q == SRead;
  assign win_wr  = state_q == SUpd;

  sram_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .clr_i    (win_clr),
    .rd_i     (win_rd),
    .wr_i     (win_wr),
    .ent_i    (win_clr ? count_q[EntW-1:0] : ent_q),
    .sample_i (item_q.sample_value),
    .sum_o    (sum)
  );

  // Arithmetic shift rounds toward minus infinity.
  assign avg = 16'(sum >>> WinW);

  assign in_if.ready  = state_q == SIdle;
  assign out_if.valid = state_q == SOut;
  assign out_if.data  = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:   if (in_if.valid) state_d = SSearch;
      SSearch: begin
        if (tail.valid) begin
          if (item_q.command == CmdMap) begin
            state_d = (!tail.hit && !full) ? SClr : SOut;
          end else begin
            state_d = tail.hit ? SRead : SOut;
          end
        end
      end
      SRead:   state_d = SOld;
      SOld:    state_d = SUpd;
      SUpd:    state_d = SAvg;
      SAvg:    state_d = SOut;
      SClr:    if (wait_q == '0) state_d = SOut;
      SOut:    if (out_if.ready) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      low_q   <= 16'sd3840;
      high_q  <= 16'sd6400;
      count_q <= '0;
      wait_q  <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i && cfg_idx_i == CfgLow) low_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CfgHigh) high_q <= cfg_data_i;
      if (win_clr) begin
        count_q <= count_q + 1'b1;
        wait_q  <= (WinW+1)'(Window);
      end else if (wait_q != '0) begin
        wait_q <= wait_q - 1'b1;
      end
    end
  end

  // Payload registers: item capture, table stores, result.
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) item_q <= in_if.data;
    if (state_q == SSearch && tail.valid) begin
      // A new map entry goes to the next free slot; its window clear follows it there.
      ent_q <= (item_q.command == CmdMap) ? count_q[EntW-1:0] : tail.idx;
      res_q.out_probe_id <= item_q.probe_id;
      res_q.out_room_id  <= '0;
      res_q.average      <= '0;
      res_q.last_time    <= '0;
      res_q.alarm        <= AlNone;
      if (item_q.command == CmdMap) begin
        res_q.status <= tail.hit ? StDup : (full ? StFull : StStored);
      end else begin
        res_q.status <= tail.hit ? StDone : StUnknown;
      end
    end
    if (win_clr) begin
      room_mem[count_q[EntW-1:0]] <= item_q.room_id;
    end
    if (state_q == SRead) begin
      room_rd_q <= room_mem[ent_q];
    end
    if (state_q == SUpd) begin
      res_q.out_room_id <= room_rd_q;
      res_q.last_time   <= item_q.sample_time;
    end
    // Average and alarm land in the cycle after the window update.
    if (state_q == SAvg) begin
      res_q.average <= avg;
      res_q.alarm   <= (avg < low_q) ? AlCold : ((avg > high_q) ? AlHot : AlNone);
    end
  end
endmodule

[hw/rtl/sram_checker.sv]
module sram_checker (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   in_valid_i,
  input logic   in_ready_i,
  input logic   out_valid_i,
  input logic   out_ready_i,
  input logic [2:0] out_status_i,
  input logic [1:0] out_alarm_i
);
  import sram_pkg::*;
`include "sensor_running_average_monitor_assert.svh"

  `SRAM_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, out_valid_i, !in_ready_i, "input taken with result pending")
  `SRAM_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped")
  `SRAM_ASSERT_IMPL(a_alarm, clk_i, rst_ni, out_valid_i && out_status_i != StDone, out_alarm_i == AlNone, "alarm off sample")
  `SRAM_ASSERT_IMPL(a_status, clk_i, rst_ni, out_valid_i, out_status_i <= StDup, "bad status")
endmodule

bind sensor_running_average_monitor sram_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_status_i (out_if.data.status),
  .out_alarm_i  (out_if.data.alarm)
);

[dv/sensor_running_average_monitor_checker.sv]
`timescale 1ns / 1ps

module sensor_running_average_monitor_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  sram_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  sram_pkg::out_item_t out_data_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_data_i,
  output int                  pending_o,
  output int                  errors_o,
  output int                  results_o
);
  import sram_pkg::*;

  logic signed [15:0] low_lim, high_lim;
  int                 n_entries;
  logic [15:0]        ids   [MaxSensors];
  logic [15:0]        rooms [MaxSensors];
  logic signed [15:0] win   [MaxSensors][Window];
  int                 wpos  [MaxSensors];
  int                 wsum  [MaxSensors];
  logic [31:0]        stamps[MaxSensors];
  out_item_t          expected_q[$];
  int                 errors, results;

  assign pending_o = expected_q.size();
  assign errors_o  = errors;
  assign results_o = results;

  task automatic report(string what, longint got, longint want);
    $display("%0t: mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Advance the sensor table by one transaction and return its outcome.
  function automatic out_item_t update_table(in_item_t it);
    out_item_t r;
    int        hit;
    int        e;
    int        avg;
    r   = '0;
    hit = -1;
    r.out_probe_id = it.probe_id;
    for (int i = 0; i < n_entries; i++)
      if (hit < 0 && ids[i] == it.probe_id) hit = i;
    if (it.command == CmdMap) begin
      if (hit >= 0) r.status = StDup;
      else if (n_entries >= MaxSensors) r.status = StFull;
      else begin
        e = n_entries;
        ids[e] = it.probe_id;
        rooms[e] = it.room_id;
        for (int k = 0; k < Window; k++) win[e][k] = '0;
        wpos[e] = 0;
        wsum[e] = 0;
        stamps[e] = '0;
        n_entries++;
        r.status = StStored;
      end
    end else if (hit < 0) begin
      r.status = StUnknown;
    end else begin
      e = hit;
      wsum[e] = wsum[e] - int'(win[e][wpos[e]]) + int'(it.sample_value);
      win[e][wpos[e]] = it.sample_value;
      wpos[e] = (wpos[e] + 1) % Window;
      stamps[e] = it.sample_time;
      avg = wsum[e] >>> WinW;  // floor division
      r.status = StDone;
      r.out_room_id = rooms[e];
      r.average = avg[15:0];
      r.last_time = stamps[e];
      if (avg < int'(low_lim)) r.alarm = AlCold;
      else if (avg > int'(high_lim)) r.alarm = AlHot;
      else r.alarm = AlNone;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      low_lim   = 16'sd3840;
      high_lim  = 16'sd6400;
      n_entries = 0;
      errors    = 0;
      results   = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgLow) low_lim = cfg_data_i;
        else high_lim = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) expected_q.push_back(update_table(in_data_i));
      if (out_valid_i && out_ready_i) begin
        results++;
        if (expected_q.size() == 0) begin
          report("unexpected result, status", out_data_i.status, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_data_i.status != want.status)
            report("status", out_data_i.status, want.status);
          if (out_data_i.out_probe_id != want.out_probe_id)
            report("probe id", out_data_i.out_probe_id, want.out_probe_id);
          if (out_data_i.out_room_id != want.out_room_id)
            report("room id", out_data_i.out_room_id, want.out_room_id);
          if (out_data_i.average != want.average)
            report("average", out_data_i.average, want.average);
          if (out_data_i.last_time != want.last_time)
            report("last time", out_data_i.last_time, want.last_time);
          if (out_data_i.alarm != want.alarm)
            report("alarm", out_data_i.alarm, want.alarm);
        end
      end
    end
  end

endmodule

[dv/sensor_running_average_monitor_tb.sv]
`timescale 1ns / 1ps

module sensor_running_average_monitor_tb;
  import sram_pkg::*;

  localparam int RandItems  = 1750;
  localparam int DrainWait  = MaxSensors + Window + 20;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        calm;     // when set, neither side idles
  int          pending, errors, results, sent;
  logic [15:0] known_ids[$];

  sram_stream_if #(.T(in_item_t))  in_ch ();
  sram_stream_if #(.T(out_item_t)) out_ch ();

  sensor_running_average_monitor dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Watch both channels and the config port; predict and compare there.
  sensor_running_average_monitor_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_i  (in_ch.ready),
    .in_data_i   (in_ch.data),
    .out_valid_i (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .out_data_i  (out_ch.data),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pending_o   (pending),
    .errors_o    (errors),
    .results_o   (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("sensor_running_average_monitor_tb: done, errors");
    $finish;
  end

  // Result side: drop ready with a chance of about 21 in a hundred unless calm.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 21);
    end
  end

  // Drive one transaction; hold valid across back-to-back items.
  task automatic send_item(in_item_t it);
    while (!calm && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_map(logic [15:0] id, logic [15:0] room);
    in_item_t it;
    it = '0;
    it.command = CmdMap;
    it.probe_id = id;
    it.room_id = room;
    it.sample_value = 16'($urandom());
    it.sample_time = $urandom();
    send_item(it);
    known_ids.push_back(id);
  endtask

  task automatic send_sample(logic [15:0] id, logic signed [15:0] val, logic [31:0] stamp);
    in_item_t it;
    it.command = CmdSample;
    it.probe_id = id;
    it.room_id = 16'($urandom());
    it.sample_value = val;
    it.sample_time = stamp;
    send_item(it);
  endtask

  // Let every result come home, then wait out any window clear in flight.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_limit(logic idx, logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pick a sample value: near a limit, at an extreme, or anywhere.
  function automatic logic signed [15:0] pick_value(logic signed [15:0] lim);
    int roll;
    roll = $urandom_range(99);
    if (roll < 40) return lim + $signed(16'($urandom_range(64))) - 16'sd32;
    if (roll < 50) return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    return 16'($urandom());
  endfunction

  initial begin
    logic signed [15:0] lo, hi;
    logic [15:0]        id;
    int                 roll;
    rst_ni = 1'b0;
    calm = 1'b0;
    sent = 0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgLow;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    lo = 16'sd3840;
    hi = 16'sd6400;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unknown id on an empty table, id extremes, duplicate,
    // a full window of maximum samples, then minimum samples.
    send_sample(16'h0005, 16'sd100, 32'h1);
    send_map(16'h0000, 16'h0000);
    send_map(16'hffff, 16'hffff);
    send_map(16'h0000, 16'h1234);
    for (int k = 0; k < Window + 1; k++)
      send_sample(16'h0000, 16'sh7fff, 32'hffffffff - k);
    for (int k = 0; k < Window + 1; k++)
      send_sample(16'hffff, 16'sh8000, k);
    send_sample(16'h1234, 16'sd0, 32'h0);
    drain();

    // Random phases, each with its own limit setting.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin lo = 16'sd3840; hi = 16'sd6400; end
        1: begin lo = 16'sh8000; hi = 16'sh7fff; end  // alarms never fire
        2: begin lo = 16'sd2000; hi = -16'sd2000; end // both crossed, cold wins
        3: begin lo = 16'sh7fff; hi = 16'sh8000; end
        default: begin lo = 16'($urandom()); hi = lo + 16'sd1500; end
      endcase
      write_limit(CfgLow, lo);
      write_limit(CfgHigh, hi);
      calm = (ph == 2);
      for (int n = 0; n < RandItems / 5; n++) begin
        roll = $urandom_range(99);
        if (roll < 14) begin
          // New ids mostly; some repeats of mapped ones.
          id = ($urandom_range(3) == 0) ? known_ids[$urandom_range(known_ids.size() - 1)]
                                        : 16'($urandom());
          send_map(id, 16'($urandom()));
        end else begin
          id = (roll < 86) ? known_ids[$urandom_range(known_ids.size() - 1)]
                           : 16'($urandom());
          send_sample(id, pick_value($urandom_range(1) ? lo : hi), $urandom());
        end
      end
      drain();
    end

    repeat (DrainWait) @(posedge clk_i);
    $display("covered %0d transactions, %0d results: table fill to full, duplicates,",
             sent, results);
    $display("unknown ids, window wrap, and five limit settings incl. extremes");
    if (errors == 0 && pending == 0) begin
      $display("sensor_running_average_monitor_tb: done, clean");
    end else begin
      $display("sensor_running_average_monitor_tb: done, errors");
    end
    $finish;
  end

endmodule
